@@ rtl/core/flc_pkg.sv @@
// Package: shared types and constants for the frame LRU slot cache.
package flc_pkg;

    localparam int SLOTS_DEF = 32;
    localparam int MAX_OUT   = 32;
    localparam int CFG_W     = 6;
    localparam logic [CFG_W-1:0] CFG_RST = 6'd32;

    localparam logic [2:0] OP_STARTED  = 3'd0;
    localparam logic [2:0] OP_FINISHED = 3'd1;
    localparam logic [2:0] OP_FAILED   = 3'd2;
    localparam logic [2:0] OP_WANTED   = 3'd3;
    localparam logic [2:0] OP_EMPTY    = 3'd4;
    localparam logic [2:0] OP_CLEAR    = 3'd5;

    typedef struct packed {
        logic [2:0]  operation;
        logic [31:0] node_id;
        logic [4:0]  slot;
        logic [31:0] tree_pos;
        logic        last;
    } t_req;

    typedef struct packed {
        logic [4:0]  target_slot;
        logic        release_valid;
        logic [31:0] released_id;
        logic        load_valid;
        logic [31:0] load_id;
        logic [31:0] load_tree_pos;
        logic        last_of_frame;
    } t_rsp;

endpackage

@@ rtl/core/flc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module flc_ram #(
    parameter int W = 32,
    parameter int D = 32
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/frame_lru_slot_cache.sv @@
// Frame LRU slot cache: loader events update the slot table, wanted blocks are looked up
// by a slot-serial walk, and the last block of a frame evicts the oldest slots. Requests are
// taken when start is high and busy is low; results come one per o_valid pulse and cannot be
// stalled. Loader started, failed, empty frame and clear are handled without leaving idle;
// finished and a wanted block walk the owner table, which has one read port that is walked
// a slot per cycle, and a wanted block's walk stops at the first hit. The last block of a
// frame then runs a full scan of the stamp table for each evicted slot, each for the oldest
// remaining slot, then a flush state for the final result, plus one more scan when the run
// stops at a slot stamped in this frame rather than at the miss count.
module frame_lru_slot_cache #(
    parameter int SLOTS = flc_pkg::SLOTS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  flc_pkg::t_req            i_req,
    input  logic                     i_cfg_we,
    input  logic [flc_pkg::CFG_W-1:0] i_cfg_data,
    output logic                     o_valid,
    output flc_pkg::t_rsp            o_rsp
);

    localparam int AW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_FIN   = 8'b0000_0010,
        S_HIT   = 8'b0000_0100,
        S_MISS  = 8'b0000_1000,
        S_SCAN  = 8'b0001_0000,
        S_PICK  = 8'b0010_0000,
        S_TAKE  = 8'b0100_0000,
        S_FLUSH = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic [flc_pkg::CFG_W-1:0] r_cfg;
    logic [31:0] r_fc, n_fc;
    logic [31:0] r_lnode, n_lnode;
    logic [4:0]  r_lslot, n_lslot;
    logic [CW-1:0] r_mc, n_mc;
    logic r_inf, n_inf;
    logic [SLOTS-1:0] r_res, n_res, r_sv, n_sv, r_taken, n_taken;
    logic [CW-1:0] r_idx, n_idx;
    logic r_pv, n_pv;
    logic [AW-1:0] r_pidx, n_pidx;
    logic [31:0] r_node, n_node, r_pos, n_pos;
    logic [4:0] r_slot, n_slot;
    logic r_last, n_last, r_hit, n_hit;
    logic [CW-1:0] r_lim, n_lim, r_k, n_k;
    logic [AW-1:0] r_best, n_best;
    logic [31:0] r_bst, n_bst;
    logic r_bf, n_bf, r_prel, n_prel, r_hp, n_hp;
    flc_pkg::t_rsp r_pend, n_pend, r_out, n_out;
    logic r_valid, n_valid;

    logic [CW-1:0] n_act;
    logic own_we, st_we, miss_we;
    logic [AW-1:0] own_wa, own_ra, st_wa, miss_wa, miss_ra;
    logic [31:0] own_wd, st_wd, own_rd, st_rd, st_v;
    logic [63:0] miss_wd, miss_rd;
    logic walk_issue, walk_done, slot_ok;
    logic [CW-1:0] mc_new;

    assign n_act = (32'(r_cfg) < SLOTS) ? CW'(r_cfg) : CW'(SLOTS);
    assign walk_issue = r_idx < n_act;
    assign walk_done = !walk_issue && !r_pv;
    assign slot_ok = 32'(i_req.slot) < 32'(n_act);
    assign st_v = r_sv[r_pidx] ? st_rd : 32'd0;

    flc_ram #(.W(32), .D(SLOTS)) u_owner (
        .i_clk(i_clk), .i_we(own_we), .i_waddr(own_wa), .i_wdata(own_wd),
        .i_raddr(own_ra), .o_rdata(own_rd)
    );
    flc_ram #(.W(32), .D(SLOTS)) u_stamp (
        .i_clk(i_clk), .i_we(st_we), .i_waddr(st_wa), .i_wdata(st_wd),
        .i_raddr(r_idx[AW-1:0]), .o_rdata(st_rd)
    );
    flc_ram #(.W(64), .D(SLOTS)) u_miss (
        .i_clk(i_clk), .i_we(miss_we), .i_waddr(miss_wa), .i_wdata(miss_wd),
        .i_raddr(miss_ra), .o_rdata(miss_rd)
    );

    always_comb begin
        n_state = r_state;
        n_fc = r_fc;
        n_lnode = r_lnode;
        n_lslot = r_lslot;
        n_mc = r_mc;
        n_inf = r_inf;
        n_res = r_res;
        n_sv = r_sv;
        n_taken = r_taken;
        n_idx = r_idx;
        n_pv = r_pv;
        n_pidx = r_pidx;
        n_node = r_node;
        n_pos = r_pos;
        n_slot = r_slot;
        n_last = r_last;
        n_hit = r_hit;
        n_lim = r_lim;
        n_k = r_k;
        n_best = r_best;
        n_bst = r_bst;
        n_bf = r_bf;
        n_prel = r_prel;
        n_hp = r_hp;
        n_pend = r_pend;
        n_out = r_out;
        n_valid = 1'b0;
        own_we = 1'b0;
        own_wa = AW'(r_slot);
        own_wd = r_node;
        own_ra = r_idx[AW-1:0];
        st_we = 1'b0;
        st_wa = AW'(r_slot);
        st_wd = r_fc;
        miss_we = 1'b0;
        miss_wa = r_mc[AW-1:0];
        miss_wd = {r_node, r_pos};
        miss_ra = r_k[AW-1:0];
        mc_new = r_mc;

        // shared slot walk: issue one read per cycle, data returns next cycle
        if (r_state == S_FIN || r_state == S_HIT || r_state == S_SCAN) begin
            n_pv = walk_issue;
            n_pidx = r_idx[AW-1:0];
            if (walk_issue) begin
                n_idx = r_idx + 1'b1;
            end
        end

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_node = i_req.node_id;
                    n_pos = i_req.tree_pos;
                    n_slot = i_req.slot;
                    n_last = i_req.last;
                    n_idx = '0;
                    n_pv = 1'b0;
                    case (i_req.operation)
                        flc_pkg::OP_STARTED: begin
                            if (slot_ok) begin
                                own_we = 1'b1;
                                own_wa = AW'(i_req.slot);
                                own_wd = i_req.node_id;
                                st_we = 1'b1;
                                st_wa = AW'(i_req.slot);
                                n_sv[AW'(i_req.slot)] = 1'b1;
                                n_res[AW'(i_req.slot)] = 1'b0;
                                n_lnode = i_req.node_id;
                                n_lslot = i_req.slot;
                            end
                        end
                        flc_pkg::OP_FINISHED: begin
                            if (slot_ok) begin
                                n_state = S_FIN;
                            end
                        end
                        flc_pkg::OP_FAILED: begin
                            if (slot_ok) begin
                                n_sv[AW'(i_req.slot)] = 1'b0;
                                n_res[AW'(i_req.slot)] = 1'b0;
                                n_lnode = '0;
                            end
                        end
                        flc_pkg::OP_WANTED, flc_pkg::OP_EMPTY: begin
                            if (i_req.operation == flc_pkg::OP_EMPTY || !r_inf) begin
                                n_fc = r_fc + 32'd1;
                                n_mc = '0;
                                if (r_lnode != '0 && 32'(r_lslot) < 32'(n_act)) begin
                                    st_we = 1'b1;
                                    st_wa = AW'(r_lslot);
                                    st_wd = r_fc + 32'd1;
                                    n_sv[AW'(r_lslot)] = 1'b1;
                                end
                            end
                            if (i_req.operation == flc_pkg::OP_EMPTY) begin
                                n_inf = 1'b0;
                            end else begin
                                n_inf = 1'b1;
                                n_hit = 1'b0;
                                n_state = (i_req.node_id != '0) ? S_HIT : S_MISS;
                            end
                        end
                        flc_pkg::OP_CLEAR: begin
                            n_res = '0;
                            n_sv = '0;
                            n_fc = 32'd1;
                            n_mc = '0;
                            n_inf = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_FIN: begin
                if (r_pv && r_pidx != AW'(r_slot) && r_res[r_pidx] && own_rd == r_node) begin
                    n_res[r_pidx] = 1'b0;
                end
                if (walk_done) begin
                    own_we = 1'b1;
                    st_we = 1'b1;
                    n_sv[AW'(r_slot)] = 1'b1;
                    n_res[AW'(r_slot)] = (r_node != '0);
                    n_lnode = '0;
                    n_state = S_IDLE;
                end
            end
            S_HIT: begin
                if (r_pv && r_res[r_pidx] && own_rd == r_node) begin
                    st_we = 1'b1;
                    st_wa = r_pidx;
                    n_sv[r_pidx] = 1'b1;
                    n_hit = 1'b1;
                    n_state = S_MISS;
                end else if (walk_done) begin
                    n_state = S_MISS;
                end
            end
            S_MISS: begin
                if (!r_hit && 32'(r_mc) < SLOTS) begin
                    miss_we = 1'b1;
                    mc_new = r_mc + 1'b1;
                end
                n_mc = mc_new;
                n_state = S_IDLE;
                if (r_last) begin
                    n_inf = 1'b0;
                    n_lim = (mc_new < n_act) ? mc_new : n_act;
                    if (32'(n_lim) > flc_pkg::MAX_OUT) begin
                        n_lim = CW'(flc_pkg::MAX_OUT);
                    end
                    n_k = '0;
                    n_taken = '0;
                    n_hp = 1'b0;
                    n_bf = 1'b0;
                    n_idx = '0;
                    n_pv = 1'b0;
                    if (n_lim != '0) begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // oldest stamp first, strict compare keeps ties on the lower slot
                if (r_pv && !r_taken[r_pidx] && (!r_bf || st_v < r_bst)) begin
                    n_bf = 1'b1;
                    n_bst = st_v;
                    n_best = r_pidx;
                end
                if (walk_done) begin
                    if (r_bf && r_bst < r_fc) begin
                        n_state = S_PICK;
                    end else begin
                        n_state = r_hp ? S_FLUSH : S_IDLE;
                    end
                end
            end
            S_PICK: begin
                own_ra = r_best;
                n_prel = r_res[r_best];
                n_res[r_best] = 1'b0;
                n_sv[r_best] = 1'b0;
                n_taken[r_best] = 1'b1;
                n_state = S_TAKE;
            end
            S_TAKE: begin
                if (r_hp) begin
                    n_valid = 1'b1;
                    n_out = r_pend;
                    n_out.last_of_frame = 1'b0;
                end
                n_pend.target_slot = 5'(r_best);
                n_pend.release_valid = r_prel;
                n_pend.released_id = r_prel ? own_rd : 32'd0;
                n_pend.load_valid = miss_rd[63:32] != '0 && miss_rd[63:32] != r_lnode;
                n_pend.load_id = n_pend.load_valid ? miss_rd[63:32] : 32'd0;
                n_pend.load_tree_pos = n_pend.load_valid ? miss_rd[31:0] : 32'd0;
                n_pend.last_of_frame = 1'b0;
                n_hp = 1'b1;
                n_k = r_k + 1'b1;
                n_bf = 1'b0;
                n_idx = '0;
                n_pv = 1'b0;
                n_state = (n_k < r_lim) ? S_SCAN : S_FLUSH;
            end
            S_FLUSH: begin
                n_valid = 1'b1;
                n_out = r_pend;
                n_out.last_of_frame = 1'b1;
                n_hp = 1'b0;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cfg <= flc_pkg::CFG_RST;
            r_fc <= 32'd1;
            r_lnode <= '0;
            r_lslot <= '0;
            r_mc <= '0;
            r_inf <= 1'b0;
            r_res <= '0;
            r_sv <= '0;
            r_taken <= '0;
            r_idx <= '0;
            r_pv <= 1'b0;
            r_hit <= 1'b0;
            r_k <= '0;
            r_lim <= '0;
            r_bf <= 1'b0;
            r_hp <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_data;
            end
            r_fc <= n_fc;
            r_lnode <= n_lnode;
            r_lslot <= n_lslot;
            r_mc <= n_mc;
            r_inf <= n_inf;
            r_res <= n_res;
            r_sv <= n_sv;
            r_taken <= n_taken;
            r_idx <= n_idx;
            r_pv <= n_pv;
            r_hit <= n_hit;
            r_k <= n_k;
            r_lim <= n_lim;
            r_bf <= n_bf;
            r_hp <= n_hp;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pidx <= n_pidx;
        r_node <= n_node;
        r_pos <= n_pos;
        r_slot <= n_slot;
        r_last <= n_last;
        r_best <= n_best;
        r_bst <= n_bst;
        r_prel <= n_prel;
        r_pend <= n_pend;
        r_out <= n_out;
    end

    assign busy = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_rsp = r_out;

endmodule

@@ rtl/core/flc_chk.sv @@
// Port-level checker for the frame LRU slot cache, bound to the top level.
module flc_chk (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input logic          o_valid,
    input flc_pkg::t_rsp o_rsp
);

    a_no_rsp_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid) else $error("result right after reset");

    a_no_rsp_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> !o_valid) else $error("result in cycle after request");

    a_more_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_rsp.last_of_frame) |-> busy) else $error("run ended without last");

    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsp.last_of_frame) |=> !o_valid) else $error("result after last");

    a_release_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_rsp.release_valid) |-> o_rsp.released_id == 32'd0)
        else $error("released id without release");

endmodule

bind frame_lru_slot_cache flc_chk u_flc_chk (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .start(start),
    .busy(busy),
    .o_valid(o_valid),
    .o_rsp(o_rsp)
);
